FILE: hdl/bshq_pkg.sv
// Shared types, constants and helper functions for the bitcrusher block.
package bshq_pkg;

  localparam int SAMPLE_W = 24;
  localparam int BITS_W   = 5;
  localparam int RATE_W   = 6;
  localparam int MIX_W    = 17;
  localparam int GAIN_W   = 16;
  localparam int CD_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int Q_DEPTH  = 2;

  localparam logic [MIX_W-1:0] MIX_ONE = 17'd65536;
  localparam logic [BITS_W-1:0] BITS_MIN = 5'd2;
  localparam logic [BITS_W-1:0] BITS_MAX = 5'd16;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DIVIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd3;

  // One queued item: dry sample and its crushed counterpart
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry;
    logic signed [SAMPLE_W-1:0] crushed;
  } item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_MIX,
    ST_ACC,
    ST_LO,
    ST_HI
  } back_state_t;

  // Limit bit depth to its legal range
  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] r;
    r = b;
    if (b < BITS_MIN) r = BITS_MIN;
    if (b > BITS_MAX) r = BITS_MAX;
    return r;
  endfunction

  // A divider of zero behaves as one
  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] d);
    return (d == '0) ? RATE_W'(1) : d;
  endfunction

  // Wet mix saturates at unity
  function automatic logic [MIX_W-1:0] clamp_mix(input logic [MIX_W-1:0] m);
    return (m > MIX_ONE) ? MIX_ONE : m;
  endfunction

  // Keep the top bits of a sample for a quantization step of 2^-bits
  function automatic logic [SAMPLE_W-1:0] crush_mask(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] sh;
    sh = BITS_W'(23) - b;
    return {SAMPLE_W{1'b1}} << sh;
  endfunction

endpackage

FILE: hdl/bshq_fifo.sv
// Short item queue between the front and back parts.
module bshq_fifo import bshq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   pop_item,
  output q_stat_t q_stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.full  = (int'(cnt_r) == Q_DEPTH);
  assign q_stat.empty = (cnt_r == '0);

endmodule

FILE: hdl/bshq_front.sv
// Front part: accepts samples, runs per-channel sample-and-hold, quantizes.
module bshq_front import bshq_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_channel,
  input  logic [BITS_W-1:0]          bits,
  input  logic [RATE_W-1:0]          rate,
  input  q_stat_t                    q_stat,
  output logic                       push,
  output item_t                      push_item
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [SAMPLE_W-1:0] held_r [CHANNELS];
  logic [CD_W-1:0]            cd_r   [CHANNELS];

  logic [CH_W-1:0]            ch_sel;
  logic signed [SAMPLE_W-1:0] held_nxt;
  logic [CD_W-1:0]            cd_nxt;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Map out-of-range channels onto the last one
  always_comb begin
    if (int'(in_channel) >= CHANNELS) begin
      ch_sel = CH_W'(CHANNELS - 1);
    end else begin
      ch_sel = CH_W'(in_channel);
    end
  end

  // Capture on an expired countdown, then count down
  always_comb begin
    if (cd_r[ch_sel] == '0) begin
      held_nxt = in_sample_in;
      cd_nxt   = CD_W'(rate) - CD_W'(1);
    end else begin
      held_nxt = held_r[ch_sel];
      cd_nxt   = cd_r[ch_sel] - CD_W'(1);
    end
  end

  assign push_item.dry     = in_sample_in;
  assign push_item.crushed = held_nxt & crush_mask(bits);

  // Update channel state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        held_r[i] <= '0;
        cd_r[i]   <= '0;
      end
    end else if (push) begin
      held_r[ch_sel] <= held_nxt;
      cd_r[ch_sel]   <= cd_nxt;
    end
  end

endmodule

FILE: hdl/bshq_back.sv
// Back part: wet/dry mix and output gain on one shared multiplier, rounding, saturation.
module bshq_back import bshq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  q_stat_t                    q_stat,
  output logic                       pop,
  input  item_t                      pop_item,
  input  logic [MIX_W-1:0]           mix,
  input  logic [GAIN_W-1:0]          gain,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped
);

  localparam int MA_W  = 26;
  localparam int MB_W  = 18;
  localparam int MP_W  = MA_W + MB_W;
  localparam int ACC_W = 41;
  localparam int LO_W  = 21;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int LOP_W = 37;
  localparam int HIP_W = 38;
  localparam int TOT_W = 60;
  localparam int SH    = 30;

  back_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] dry_r;
  logic signed [MP_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [HIP_W-1:0]    hi_r;
  logic [LOP_W-1:0]           lo_r;
  logic                       fin_vld_r;
  logic                       out_vld_r;
  logic signed [SAMPLE_W-1:0] out_smp_r;
  logic                       out_clip_r;

  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [MP_W-1:0]     mul_p;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [HI_W-1:0]     acc_hi;
  logic                       fin_take;
  logic                       hi_done;
  logic signed [TOT_W-1:0]    total;
  logic signed [TOT_W-1:0]    rnd;
  logic signed [TOT_W-SH-1:0] res;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       clip;

  assign fin_take = fin_vld_r && (!out_vld_r || out_ready);
  assign hi_done  = (state_r == ST_HI) && (!fin_vld_r || fin_take);

  // Upper accumulator half keeps the sign
  assign acc_hi = acc_r[ACC_W-1:LO_W];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_MIX: if (!q_stat.empty) state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_LO;
      ST_LO:  state_nxt = ST_HI;
      ST_HI:  if (hi_done) state_nxt = ST_MIX;
      default: state_nxt = ST_MIX;
    endcase
  end

  // Multiplier operands and queue pop
  always_comb begin
    diff  = {pop_item.crushed[SAMPLE_W-1], pop_item.crushed}
          - {pop_item.dry[SAMPLE_W-1], pop_item.dry};
    pop   = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MIX: begin
        pop   = !q_stat.empty;
        mul_a = MA_W'(diff);
        mul_b = {1'b0, mix};
      end
      ST_LO: begin
        mul_a = {{(MA_W-LO_W){1'b0}}, acc_r[LO_W-1:0]};
        mul_b = {2'b00, gain};
      end
      ST_HI: begin
        mul_a = MA_W'(acc_hi);
        mul_b = {2'b00, gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MIX;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      dry_r  <= pop_item.dry;
      prod_r <= mul_p;
    end
    if (state_r == ST_ACC) begin
      acc_r <= {dry_r[SAMPLE_W-1], dry_r, 16'b0} + prod_r[ACC_W-1:0];
    end
    if (state_r == ST_LO) begin
      prod_r <= mul_p;
    end
    if (hi_done) begin
      hi_r <= mul_p[HIP_W-1:0];
      lo_r <= prod_r[LOP_W-1:0];
    end
  end

  // Recombine partial products, round half up, saturate
  always_comb begin
    total = (TOT_W'(hi_r) <<< LO_W) + TOT_W'({1'b0, lo_r});
    rnd   = total + (TOT_W'(1) <<< (SH - 1));
    res   = rnd[TOT_W-1:SH];
    clip  = 1'b0;
    sat   = res[SAMPLE_W-1:0];
    if (res > (TOT_W-SH)'(SAMPLE_MAX)) begin
      sat  = SAMPLE_MAX;
      clip = 1'b1;
    end else if (res < (TOT_W-SH)'(SAMPLE_MIN)) begin
      sat  = SAMPLE_MIN;
      clip = 1'b1;
    end
  end

  // Final stage and output register valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (hi_done) begin
        fin_vld_r <= 1'b1;
      end else if (fin_take) begin
        fin_vld_r <= 1'b0;
      end
      if (fin_take) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold result until transfer
  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_smp_r  <= sat;
      out_clip_r <= clip;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_sample_out = out_smp_r;
  assign out_clipped    = out_clip_r;

endmodule

FILE: hdl/bitcrusher_sample_hold_quantize.sv
// Top level of the bitcrusher: configuration registers, front, queue and back.
// Each sample passes a front stage that updates its channel's sample-and-hold
// state and quantizes the held value in the cycle it is accepted, then waits in
// a two-entry queue. The back end steps through mix, accumulate, low and high
// states for each sample so that its single shared 26x18 multiplier serves the
// wet mix, then gain as low and high halves; a final stage rounds and saturates
// while the next sample starts, and the high state holds while that final stage
// is blocked by the output. Configuration writes take effect at once and are
// meant for idle periods only.
module bitcrusher_sample_hold_quantize import bshq_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_channel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  logic [BITS_W-1:0] bit_depth_r;
  logic [RATE_W-1:0] rate_divide_r;
  logic [MIX_W-1:0]  wet_mix_r;
  logic [GAIN_W-1:0] output_gain_r;

  logic    push, pop;
  item_t   push_item, pop_item;
  q_stat_t q_stat;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_depth_r   <= 5'd8;
      rate_divide_r <= 6'd4;
      wet_mix_r     <= MIX_ONE;
      output_gain_r <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_DEPTH:   bit_depth_r   <= cfg_wdata[BITS_W-1:0];
        REG_RATE_DIVIDE: rate_divide_r <= cfg_wdata[RATE_W-1:0];
        REG_WET_MIX:     wet_mix_r     <= cfg_wdata[MIX_W-1:0];
        REG_OUTPUT_GAIN: output_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  bshq_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .in_channel   (in_channel),
    .bits         (clamp_bits(bit_depth_r)),
    .rate         (clamp_rate(rate_divide_r)),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  bshq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  bshq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop            (pop),
    .pop_item       (pop_item),
    .mix            (clamp_mix(wet_mix_r)),
    .gain           (output_gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

  // Queue is never full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // A clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_sample_out == SAMPLE_MAX || out_sample_out == SAMPLE_MIN))
    else $error("clipped result off the rail");

  // Reset leaves no result pending
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Front stalls only when the queue is full
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> q_stat.full)
    else $error("input stalled with room in queue");

endmodule
